>>> rtl/core/ovn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise package
// Shared widths, hash constants, the quarter-wave cosine table and the
// structs that pass between the front, the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ovn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COS_DEPTH   = 256;
  localparam int MAX_OCTAVES = 8;

  localparam int COORD_W     = 32;
  localparam int OCT_REG_W   = 4;
  localparam int PERS_W      = 17;
  localparam int PERS_FRAC   = 16;
  // Persistence is below 2.0, so the amplitude gains under one bit per octave.
  localparam int AMP_W       = PERS_FRAC + MAX_OCTAVES;
  localparam int NOISE_W     = 18;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 17;

  localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);
  localparam int O_W     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int P_SH    = $clog2(2 * COS_DEPTH);
  localparam int P_W     = P_SH + 1;
  localparam int CIDX_W  = $clog2(COS_DEPTH + 1);
  localparam int COS_W   = 17;
  localparam int W_W     = 18;
  localparam int LAT_W   = 32;
  localparam int SM_W    = 36;
  localparam int OV_W    = 26;
  localparam int SUM_W   = AMP_W + $clog2(MAX_OCTAVES);
  localparam int DEN_W   = SUM_W + 8;
  localparam int TOT_W   = OV_W + SUM_W;
  localparam int QUO_W   = 18;

  localparam logic [CFG_ADDR_W-1:0] REG_OCTAVES     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERSISTENCE = 1'd1;

  localparam logic [OCT_REG_W-1:0] OCTAVES_RST     = 4'd4;
  localparam logic [PERS_W-1:0]    PERSISTENCE_RST = 17'd32768;
  localparam logic [AMP_W-1:0]     AMP_ONE         = AMP_W'(32'd65536);
  localparam logic [W_W-1:0]       COS_ONE         = 18'd65536;

  localparam logic [31:0] HASH_ROW = 32'd57;
  localparam logic [31:0] HASH_K1  = 32'd15731;
  localparam logic [31:0] HASH_K2  = 32'd789221;
  localparam logic [31:0] HASH_K3  = 32'd1376312589;
  localparam logic [31:0] HASH_MSK = 32'h7FFFFFFF;
  localparam logic signed [31:0] LAT_BIAS = 32'sh40000000;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  // Series terms stay below 2^32 in magnitude once scaled back to Q30.
  localparam int TAB_DIV_BITS = 36;

  typedef logic [COS_W-1:0] cos_tab_t [0:COS_DEPTH];

  // Q30 product scaled back toward zero.
  function automatic longint trunc_q30(longint v);
    return (v < 0) ? -((-v) >>> 30) : (v >>> 30);
  endfunction

  // Shift and subtract division that truncates toward zero.
  function automatic longint trunc_div(longint num, longint den);
    longint n_mag;
    longint d_mag;
    longint quo;
    longint rem;
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    quo   = 0;
    rem   = 0;
    for (int b = TAB_DIV_BITS - 1; b >= 0; b--) begin
      rem = (rem <<< 1) | ((n_mag >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= d_mag) begin
        rem = rem - d_mag;
        quo = quo | 64'sd1;
      end
    end
    return ((num < 0) != (den < 0)) ? -quo : quo;
  endfunction

  // Taylor series of cos in Q30 with truncating division, rounded into Q16.
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t tab;
    longint   ang;
    longint   a2;
    longint   term;
    longint   sum;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      ang  = (HALF_PI_Q30 * longint'(k)) >>> $clog2(COS_DEPTH);
      a2   = (ang * ang) >>> 30;
      term = ONE_Q30;
      sum  = term;
      for (int n = 1; n <= 10; n++) begin
        term = -trunc_div(trunc_q30(term * a2), longint'((2 * n - 1) * (2 * n)));
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[k] = COS_W'((sum + 64'sd8192) >>> 14);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [CNT_W-1:0]          count;
  } ovn_item_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [AMP_W-1:0] amp;
  } ovn_tag_t;

endpackage

>>> rtl/core/octave_value_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise 2D
// Fractal value noise of one Q16.16 point per request, Q1.16 result.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  s_*     | in        | tdata[31:0] coord_x, tdata[63:32] coord_y
//  m_*     | out       | tdata[17:0] noise_value, tdata[23:18] zero
//  cfg_*   | in        | addr 0 octaves (wdata[3:0]), addr 1 persistence
//
// A request occupies the octave evaluator for one cycle per octave, and the next
// request is taken as its last octave issues, while an output credit is free.
// Each request holds one of OUT_DEPTH output credits from the time it is taken
// until its result leaves the output queue, so a stalled receiver holds off s_*.
// A result passes the 10-stage evaluator, the accumulator and the 18-stage
// divider before m_tvalid rises. Reset is synchronous.
// ----------------------------------------------------------------------------
module octave_value_noise_2d import ovn_pkg::*; #(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [63:0]           s_tdata,   // coord_x, coord_y
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // noise_value, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [OCT_REG_W-1:0] octaves;
  logic [PERS_W-1:0]    persistence;
  logic                 item_valid;
  logic                 item_ready;
  ovn_item_t            item;

  always_ff @(posedge clk) begin
    if (rst) begin
      octaves     <= OCTAVES_RST;
      persistence <= PERSISTENCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OCTAVES:     octaves     <= cfg_wdata[OCT_REG_W-1:0];
        REG_PERSISTENCE: persistence <= cfg_wdata[PERS_W-1:0];
        default: ;
      endcase
    end
  end

  ovn_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .octaves    (octaves),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  ovn_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .persistence (persistence),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

>>> rtl/core/ovn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise front end
// Accepts sample requests, clamps the octave count and queues them for the
// octave sequencer.
// ----------------------------------------------------------------------------
module ovn_front import ovn_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [63:0]          s_tdata,
  input  logic [OCT_REG_W-1:0] octaves,
  output logic                 item_valid,
  input  logic                 item_ready,
  output ovn_item_t            item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  ovn_item_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;
  ovn_item_t         incoming;
  logic [CNT_W-1:0]  count;

  // Zero octaves run as one; anything above the maximum is cut back.
  always_comb begin
    if (octaves == '0) begin
      count = CNT_W'(1);
    end else if (CNT_W'(octaves) > CNT_W'(MAX_OCTAVES)) begin
      count = CNT_W'(MAX_OCTAVES);
    end else begin
      count = CNT_W'(octaves);
    end
  end

  assign incoming.coord_x = s_tdata[31:0];
  assign incoming.coord_y = s_tdata[63:32];
  assign incoming.count   = count;

  assign s_tready   = (fill != FILL_W'(DEPTH));
  assign item_valid = (fill != '0);
  assign item       = mem[rd_ptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(push) - FILL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= incoming;
    end
  end

endmodule

>>> rtl/core/ovn_octave.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave evaluator
// Ten-stage pipeline that takes one octave of one sample per cycle: lattice
// hash over a 4x4 neighborhood, 3x3 smoothing, cosine blend along x then y.
// ----------------------------------------------------------------------------
module ovn_octave import ovn_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic [O_W-1:0]            oct_idx,
  input  ovn_tag_t                  in_tag,
  output logic                      out_valid,
  output logic signed [OV_W-1:0]    value,
  output ovn_tag_t                  out_tag
);

  localparam int NSTG  = 10;
  localparam int EXT_W = 64;
  localparam int LANES = 16;
  localparam int R_W   = SM_W + 1;
  localparam int PX_W  = R_W + W_W + 1;
  localparam int PY_W  = R_W + 1 + W_W + 1;

  logic     vld [1:NSTG];
  ovn_tag_t tg  [1:NSTG];

  logic [EXT_W-1:0] sx;
  logic [EXT_W-1:0] sy;
  logic [31:0]          s1_ix, s1_iy;
  logic [FRAC_BITS-1:0] s1_tx, s1_ty;

  logic [FRAC_BITS+P_SH:0] px_full, py_full;
  logic [P_W-1:0]          px, py;
  logic [CIDX_W-1:0] s2_idx_x, s2_idx_y;
  logic              s2_neg_x, s2_neg_y;
  logic [W_W-1:0]    s3_wx, s3_wy, s4_wx, s4_wy, s5_wx, s5_wy, s6_wx, s6_wy;
  logic [W_W-1:0]    s7_wy, s8_wy;

  logic [31:0]              s2_m  [LANES];
  logic [31:0]              s3_m  [LANES];
  logic [31:0]              s3_mm [LANES];
  logic [31:0]              s4_m  [LANES];
  logic [31:0]              s4_q  [LANES];
  logic signed [LAT_W-1:0]  s5_l  [LANES];
  logic signed [SM_W-1:0]   sm    [4];
  logic signed [SM_W-1:0]   s6_s  [4];

  logic signed [PX_W-1:0] s7_p0, s7_p1;
  logic signed [R_W-1:0]  s7_a0, s7_a1;
  logic signed [R_W-1:0]  s8_r0, s8_r1;
  logic signed [PY_W-1:0] s9_p;
  logic signed [R_W-1:0]  s9_a;
  logic signed [PY_W-1:0] fin;
  logic signed [OV_W-1:0] s10_v;

  localparam logic [FRAC_BITS+P_SH:0] P_HALF = (FRAC_BITS+P_SH+1)'(1) << (FRAC_BITS - 1);

  function automatic logic signed [SM_W-1:0] lat_ext(input logic signed [LAT_W-1:0] v);
    return SM_W'(v);
  endfunction

  // Valid and tag shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) begin
        vld[k] <= 1'b0;
      end
    end else begin
      vld[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tg[1] <= in_tag;
    for (int k = 2; k <= NSTG; k++) begin
      tg[k] <= tg[k-1];
    end
  end

  // Stage 1: scale by the octave and split into lattice cell and fraction.
  assign sx = {{(EXT_W-COORD_W){coord_x[COORD_W-1]}}, coord_x} << oct_idx;
  assign sy = {{(EXT_W-COORD_W){coord_y[COORD_W-1]}}, coord_y} << oct_idx;

  always_ff @(posedge clk) begin
    s1_ix <= sx[FRAC_BITS+31:FRAC_BITS];
    s1_iy <= sy[FRAC_BITS+31:FRAC_BITS];
    s1_tx <= sx[FRAC_BITS-1:0];
    s1_ty <= sy[FRAC_BITS-1:0];
  end

  // Stage 2: table position; the second quarter mirrors with negated cosine.
  assign px_full = {1'b0, s1_tx, P_SH'(0)} + P_HALF;
  assign py_full = {1'b0, s1_ty, P_SH'(0)} + P_HALF;
  assign px = px_full[FRAC_BITS+P_SH:FRAC_BITS];
  assign py = py_full[FRAC_BITS+P_SH:FRAC_BITS];

  always_ff @(posedge clk) begin
    s2_neg_x <= (px > P_W'(COS_DEPTH));
    s2_neg_y <= (py > P_W'(COS_DEPTH));
    s2_idx_x <= (px > P_W'(COS_DEPTH)) ? CIDX_W'(P_W'(2 * COS_DEPTH) - px) : CIDX_W'(px);
    s2_idx_y <= (py > P_W'(COS_DEPTH)) ? CIDX_W'(P_W'(2 * COS_DEPTH) - py) : CIDX_W'(py);
  end

  // Stage 3: blend weights in Q17, then carried alongside the hash lanes.
  always_ff @(posedge clk) begin
    s3_wx <= s2_neg_x ? COS_ONE + W_W'(COS_TAB[s2_idx_x]) : COS_ONE - W_W'(COS_TAB[s2_idx_x]);
    s3_wy <= s2_neg_y ? COS_ONE + W_W'(COS_TAB[s2_idx_y]) : COS_ONE - W_W'(COS_TAB[s2_idx_y]);
    s4_wx <= s3_wx;
    s4_wy <= s3_wy;
    s5_wx <= s4_wx;
    s5_wy <= s4_wy;
    s6_wx <= s5_wx;
    s6_wy <= s5_wy;
    s7_wy <= s6_wy;
    s8_wy <= s7_wy;
  end

  // Hash lanes: lane l covers cell offset (l%4 - 1, l/4 - 1).
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    localparam logic [31:0] DX = 32'(l % 4) - 32'd1;
    localparam logic [31:0] DY = 32'(l / 4) - 32'd1;
    logic [31:0] m0;
    logic [31:0] h;

    assign m0 = (s1_ix + DX) + (s1_iy + DY) * HASH_ROW;
    assign h  = (s4_m[l] * s4_q[l] + HASH_K3) & HASH_MSK;

    always_ff @(posedge clk) begin
      s2_m[l]  <= m0 ^ (m0 << 13);
      s3_m[l]  <= s2_m[l];
      s3_mm[l] <= s2_m[l] * s2_m[l];
      s4_m[l]  <= s3_m[l];
      s4_q[l]  <= s3_mm[l] * HASH_K1 + HASH_K2;
      s5_l[l]  <= LAT_BIAS - $signed(h);
    end
  end

  // Stage 6: smoothed value for each cell corner, centre at grid (cx+1, cy+1).
  for (genvar c = 0; c < 4; c++) begin : g_corner
    localparam int CX = c % 2;
    localparam int CY = c / 2;
    logic signed [SM_W-1:0] diag;
    logic signed [SM_W-1:0] side;
    logic signed [SM_W-1:0] cen;

    assign diag = lat_ext(s5_l[CY*4 + CX]) + lat_ext(s5_l[CY*4 + CX + 2])
                + lat_ext(s5_l[(CY+2)*4 + CX]) + lat_ext(s5_l[(CY+2)*4 + CX + 2]);
    assign side = lat_ext(s5_l[(CY+1)*4 + CX]) + lat_ext(s5_l[(CY+1)*4 + CX + 2])
                + lat_ext(s5_l[CY*4 + CX + 1]) + lat_ext(s5_l[(CY+2)*4 + CX + 1]);
    assign cen  = lat_ext(s5_l[(CY+1)*4 + CX + 1]);
    assign sm[c] = diag + (side <<< 1) + (cen <<< 2);

    always_ff @(posedge clk) begin
      s6_s[c] <= sm[c];
    end
  end

  // Stages 7-8: blend along x for the lower and upper rows.
  always_ff @(posedge clk) begin
    s7_a0 <= R_W'(s6_s[0]);
    s7_a1 <= R_W'(s6_s[2]);
    s7_p0 <= (R_W'(s6_s[1]) - R_W'(s6_s[0])) * $signed({1'b0, s6_wx});
    s7_p1 <= (R_W'(s6_s[3]) - R_W'(s6_s[2])) * $signed({1'b0, s6_wx});
    s8_r0 <= R_W'(PX_W'(s7_a0) + (s7_p0 >>> 17));
    s8_r1 <= R_W'(PX_W'(s7_a1) + (s7_p1 >>> 17));
  end

  // Stages 9-10: blend along y and drop to Q24.
  assign fin = (PY_W'(s9_a) + (s9_p >>> 17)) >>> 10;

  always_ff @(posedge clk) begin
    s9_a  <= s8_r0;
    s9_p  <= ((R_W+1)'(s8_r1) - (R_W+1)'(s8_r0)) * $signed({1'b0, s8_wy});
    s10_v <= OV_W'(fin);
  end

  assign out_valid = vld[NSTG];
  assign out_tag   = tg[NSTG];
  assign value     = s10_v;

endmodule

>>> rtl/core/ovn_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave accumulator and normalizer
// Weights each octave by its amplitude, sums a sample's octaves and divides
// by the amplitude sum in a pipelined restoring divider, one bit per stage.
// ----------------------------------------------------------------------------
module ovn_norm import ovn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [OV_W-1:0]  value,
  input  ovn_tag_t                in_tag,
  output logic                    res_valid,
  output logic [NOISE_W-1:0]      res
);

  localparam int PR_W = OV_W + AMP_W + 1;
  localparam int Q_W  = NOISE_W + 1;

  logic                    a_vld;
  ovn_tag_t                a_tag;
  logic signed [PR_W-1:0]  a_prod;
  logic signed [TOT_W-1:0] acc_tot;
  logic [SUM_W-1:0]        acc_sum;
  logic signed [TOT_W-1:0] tot_now;
  logic [SUM_W-1:0]        sum_now;
  logic                    b_vld;
  logic signed [TOT_W-1:0] b_tot;
  logic [SUM_W-1:0]        b_sum;

  logic             dv_vld [0:QUO_W];
  logic [TOT_W-1:0] dv_rem [0:QUO_W];
  logic [DEN_W-1:0] dv_den [0:QUO_W];
  logic [QUO_W-1:0] dv_quo [0:QUO_W];
  logic             dv_neg [0:QUO_W];

  logic signed [Q_W-1:0] q_floor;
  logic signed [Q_W-1:0] q_sat;

  // Stage A: octave value times amplitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_tag  <= in_tag;
    a_prod <= value * $signed({1'b0, in_tag.amp});
  end

  // Stage B: running sums, restarted by the first octave of each sample.
  assign tot_now = a_tag.first ? TOT_W'(a_prod) : acc_tot + TOT_W'(a_prod);
  assign sum_now = a_tag.first ? SUM_W'(a_tag.amp) : acc_sum + SUM_W'(a_tag.amp);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld && a_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld) begin
      acc_tot <= tot_now;
      acc_sum <= sum_now;
    end
    b_tot <= tot_now;
    b_sum <= sum_now;
  end

  // Stage C: magnitude and denominator into the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    dv_neg[0] <= b_tot[TOT_W-1];
    dv_rem[0] <= b_tot[TOT_W-1] ? TOT_W'(-b_tot) : TOT_W'(b_tot);
    dv_den[0] <= DEN_W'(b_sum) << 8;
    dv_quo[0] <= '0;
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_div
    localparam int B = QUO_W - 1 - s;
    logic [TOT_W-1:0] trial;
    logic             fit;

    assign trial = TOT_W'(dv_den[s]) << B;
    assign fit   = (dv_rem[s] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[s+1] <= 1'b0;
      end else begin
        dv_vld[s+1] <= dv_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[s+1] <= fit ? dv_rem[s] - trial : dv_rem[s];
      dv_quo[s+1] <= {dv_quo[s][QUO_W-2:0], fit};
      dv_den[s+1] <= dv_den[s];
      dv_neg[s+1] <= dv_neg[s];
    end
  end

  // A negative sum with a remainder rounds one further down.
  always_comb begin
    if (dv_neg[QUO_W]) begin
      q_floor = -(Q_W'(dv_quo[QUO_W]) + Q_W'(|dv_rem[QUO_W]));
    end else begin
      q_floor = Q_W'(dv_quo[QUO_W]);
    end
    if (q_floor > $signed(Q_W'(AMP_ONE))) begin
      q_sat = $signed(Q_W'(AMP_ONE));
    end else if (q_floor < -$signed(Q_W'(AMP_ONE))) begin
      q_sat = -$signed(Q_W'(AMP_ONE));
    end else begin
      q_sat = q_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= dv_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    res <= NOISE_W'(q_sat);
  end

endmodule

>>> rtl/core/ovn_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise back end
// Steps each queued sample through its octaves, one per cycle, into the
// octave evaluator and normalizer, and holds results in an output queue.
// ----------------------------------------------------------------------------
module ovn_back import ovn_pkg::*; #(
  parameter int OUT_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ovn_item_t         item,
  input  logic [PERS_W-1:0] persistence,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata
);

  localparam int PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int FILL_W = $clog2(OUT_DEPTH + 1);

  logic                     busy;
  ovn_item_t                cur;
  logic [O_W-1:0]           oct_idx;
  logic [AMP_W-1:0]         amp;
  logic [AMP_W+PERS_W-1:0]  amp_prod;
  logic                     issue_last;
  logic                     load;
  logic                     credit_ok;
  logic [FILL_W-1:0]        credits;
  ovn_tag_t                 tag;

  logic                     ov_valid;
  logic signed [OV_W-1:0]   ov_value;
  ovn_tag_t                 ov_tag;
  logic                     res_valid;
  logic [NOISE_W-1:0]       res;

  logic [NOISE_W-1:0] mem [OUT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               pop;

  // Every sample in flight holds a slot in the output queue, so the
  // datapath never has to stall.
  assign credit_ok  = (credits != FILL_W'(OUT_DEPTH));
  assign issue_last = busy && (oct_idx == O_W'(cur.count - CNT_W'(1)));
  assign item_ready = (!busy || issue_last) && credit_ok;
  assign load       = item_valid && item_ready;
  assign pop        = m_tvalid && m_tready;
  assign amp_prod   = amp * persistence;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      credits <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (issue_last) begin
        busy <= 1'b0;
      end
      credits <= credits + FILL_W'(load) - FILL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur     <= item;
      oct_idx <= '0;
      amp     <= AMP_ONE;
    end else if (busy) begin
      oct_idx <= oct_idx + O_W'(1);
      amp     <= AMP_W'(amp_prod >> PERS_FRAC);
    end
  end

  assign tag.first = (oct_idx == '0);
  assign tag.last  = issue_last;
  assign tag.amp   = amp;

  ovn_octave u_octave (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (busy),
    .coord_x   (cur.coord_x),
    .coord_y   (cur.coord_y),
    .oct_idx   (oct_idx),
    .in_tag    (tag),
    .out_valid (ov_valid),
    .value     (ov_value),
    .out_tag   (ov_tag)
  );

  ovn_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ov_valid),
    .value     (ov_value),
    .in_tag    (ov_tag),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(res_valid) - FILL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      mem[wr_ptr] <= res;
    end
  end

  assign m_tvalid = (fill != '0);
  assign m_tdata  = {{(24-NOISE_W){1'b0}}, mem[rd_ptr]};

endmodule

>>> rtl/core/ovn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise port checker
// Watches the stream ports for reset behavior, result range, padding and holding.
// ----------------------------------------------------------------------------
module ovn_checker import ovn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Nothing is owed right after reset, and the input queue is open.
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("outputs not idle after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[NOISE_W-1:0]) <= $signed(NOISE_W'(AMP_ONE)))
              && ($signed(m_tdata[NOISE_W-1:0]) >= -$signed(NOISE_W'(AMP_ONE))))
    else $error("noise value outside [-1, 1]");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:NOISE_W] == '0))
    else $error("nonzero padding in result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Request taken, no result valid: always holds, as $past(m_tvalid) is low.
  a_no_input_without_valid: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !(m_tvalid && $past(m_tvalid)))
    else $error("result appeared too early");

endmodule

bind octave_value_noise_2d ovn_checker u_ovn_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise 2D testbench
// Drives Q16.16 points into the noise block under several octave and
// persistence settings and with random idle gaps on both sides. Each noise
// value is checked against a predictor built into this bench.
// ----------------------------------------------------------------------------
module tb;
  import ovn_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [63:0]           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  octave_value_noise_2d uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0]        cosine_q16 [0:COS_DEPTH];
  logic [3:0]         octave_reg;
  logic [16:0]        pers_reg;
  logic signed [17:0] noise_queue [$];
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 error_count;
  int                 noise_count;
  longint             cycle_count;

  // Same Taylor recipe as the hardware table, written independently.
  task automatic fill_cosine();
    longint ang, a2, term, acc;
    for (int k = 0; k <= COS_DEPTH; k++) begin
      ang  = 64'sd1686629713 * k / COS_DEPTH;
      a2   = (ang * ang) >>> 30;
      term = 64'sd1 << 30;
      acc  = term;
      for (int n = 1; n <= 10; n++) begin
        term = -((term * a2) / (64'sd1 << 30)) / ((2 * n - 1) * (2 * n));
        acc  = acc + term;
      end
      if (acc < 0) begin
        acc = 0;
      end
      cosine_q16[k] = 32'((acc + 8192) >>> 14);
    end
  endtask

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint lattice_val(logic [31:0] i, logic [31:0] j);
    logic [31:0] m, h;
    m = i + j * 32'd57;
    m = (m << 13) ^ m;
    h = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7FFFFFFF;
    return (64'sd1 << 30) - longint'({32'd0, h});
  endfunction

  function automatic longint smooth_val(logic [31:0] i, logic [31:0] j);
    longint d, sd;
    d  = lattice_val(i - 1, j - 1) + lattice_val(i + 1, j - 1)
       + lattice_val(i - 1, j + 1) + lattice_val(i + 1, j + 1);
    sd = lattice_val(i - 1, j) + lattice_val(i + 1, j)
       + lattice_val(i, j + 1) + lattice_val(i, j - 1);
    return d + 2 * sd + 4 * lattice_val(i, j);
  endfunction

  function automatic longint cos_weight(logic [15:0] t);
    longint p, c;
    p = (longint'(t) * 2 * COS_DEPTH + 32768) >>> 16;
    if (p <= COS_DEPTH) c = cosine_q16[p];
    else c = -longint'(cosine_q16[2 * COS_DEPTH - p]);
    return 65536 - c;
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + floor_sh((b - a) * w, 17);
  endfunction

  function automatic longint octave_noise(logic [31:0] x, logic [31:0] y, int o);
    logic [63:0] sx, sy;
    logic [31:0] ix, iy;
    longint wx, wy, r0, r1;
    sx = {{32{x[31]}}, x} << o;
    sy = {{32{y[31]}}, y} << o;
    ix = sx[47:16];
    iy = sy[47:16];
    wx = cos_weight(sx[15:0]);
    wy = cos_weight(sy[15:0]);
    r0 = mix(smooth_val(ix, iy), smooth_val(ix + 1, iy), wx);
    r1 = mix(smooth_val(ix, iy + 1), smooth_val(ix + 1, iy + 1), wx);
    return floor_sh(mix(r0, r1, wy), 10);
  endfunction

  function automatic logic signed [17:0] fractal_noise(logic [31:0] x, logic [31:0] y);
    int     cnt;
    longint amp, amp_sum, total, den, q;
    cnt = (octave_reg == 0) ? 1 : (octave_reg > MAX_OCTAVES) ? MAX_OCTAVES : octave_reg;
    amp = 65536;
    amp_sum = 0;
    total = 0;
    for (int o = 0; o < cnt; o++) begin
      total += octave_noise(x, y, o) * amp;
      amp_sum += amp;
      amp = (amp * pers_reg) >>> 16;
    end
    den = amp_sum * 256;
    q = total / den;
    if (total % den != 0 && total < 0) q--;
    if (q > 65536) q = 65536;
    if (q < -65536) q = -65536;
    return 18'(q);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd3000000) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (noise_queue.size() == 0) begin
          $display("%0t: unexpected noise value %0d", $time, $signed(m_tdata[17:0]));
          error_count++;
        end else begin
          if (m_tdata[17:0] !== noise_queue[0] || m_tdata[23:18] !== 6'd0) begin
            $display("%0t: noise mismatch expected %0d actual %0d (pad %h)", $time,
                     noise_queue[0], $signed(m_tdata[17:0]), m_tdata[23:18]);
            error_count++;
          end
          void'(noise_queue.pop_front());
          noise_count++;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The request stays valid after its handshake until the next gap or drain.
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    noise_queue.push_back(fractal_noise(x, y));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (noise_queue.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [16:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_OCTAVES) octave_reg = val[3:0];
    else pers_reg = val;
  endtask

  task automatic set_pace(int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
  endtask

  task automatic test_directed();
    logic [31:0] pts [10];
    pts = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00008000,
            32'h0000FFFF, 32'h00010000, 32'h7FFF8000, 32'h80007FFF, 32'h12345678};
    for (int k = 0; k < 10; k++) send_point(pts[k], pts[9 - k]);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000);
    // Octaves zero acts as one; values above the maximum saturate.
    write_reg(REG_OCTAVES, 17'd0);
    send_point(32'h00018000, 32'hFFFE4000);
    write_reg(REG_OCTAVES, 17'd15);
    write_reg(REG_PERSISTENCE, 17'h1FFFF);
    send_point(32'h7FFFFFFF, 32'h80000001);
    send_point(32'h00004000, 32'h0000C000);
    write_reg(REG_PERSISTENCE, 17'd0);
    send_point(32'hABCDEF01, 32'h10203040);
  endtask

  task automatic random_points(int n);
    logic [31:0] x, y;
    for (int k = 0; k < n; k++) begin
      x = $urandom();
      y = $urandom();
      // A quarter of the points get small coordinates; the rest are full-range.
      if ($urandom_range(3) == 0) begin
        x = {{14{x[31]}}, x[17:0]};
        y = {{14{y[31]}}, y[17:0]};
      end
      send_point(x, y);
    end
  endtask

  task automatic test_random();
    int octs [6] = '{1, 8, 3, 0, 12, 5};
    logic [16:0] pers [6] = '{17'd65536, 17'd0, 17'd32768, 17'd45000, 17'd100000, 17'd1};
    int idles [4] = '{0, 85, 0, 23};
    int stalls [4] = '{0, 0, 85, 23};
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_OCTAVES, 17'(octs[ph % 6]));
      write_reg(REG_PERSISTENCE, pers[(ph + 2) % 6]);
      set_pace(idles[ph % 4], stalls[ph % 4]);
      random_points(100);
    end
    set_pace(0, 0);
  endtask

  initial begin
    error_count = 0;
    noise_count = 0;
    cycle_count = 0;
    octave_reg  = OCTAVES_RST;
    pers_reg    = PERSISTENCE_RST;
    set_pace(0, 0);
    fill_cosine();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    $display("Checked %0d noise values over twelve octave/persistence settings,", noise_count);
    $display("including octave saturation and zero, with random gaps and stalls.");
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
